[hw/rtl/mfsa_pkg.sv]
// Shared constants, codes and types of the mean-field spin annealer.
`default_nettype none

package mfsa_pkg;

	localparam int SPIN_COUNT = 32;
	localparam int IDX_W      = $clog2(SPIN_COUNT);
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int CNT_W      = IDX_W + 1;
	localparam int JMEM_DEPTH = SPIN_COUNT * SPIN_COUNT;

	// Field sum: N products of Q3.12 by Q1.15.
	localparam int ACC_W  = 32 + IDX_W;
	localparam int SQS_W  = 31 + IDX_W;
	localparam int OMQ_W  = 31;
	localparam int TPR_W  = OMQ_W + 1 + 16;
	localparam int F_W    = ACC_W + 1;
	localparam int NRM_W  = 31;
	localparam int SQ_W   = 2 * NRM_W;
	localparam int RAD_W  = 64;
	localparam int HEFF_W = 32;
	localparam int QUO_W  = 17;
	localparam int NUM_W  = NRM_W + 16;
	localparam int REM_W  = HEFF_W + 1;
	localparam int DCNT_W = $clog2(QUO_W + 1);
	localparam int EPR_W  = ACC_W + 16;
	localparam int ETOT_W = EPR_W - 16 + IDX_W;
	localparam int E_SH   = $clog2(2 * SPIN_COUNT * 1024);

	typedef enum logic [1:0] {
		FN_LOAD_J = 2'd0,
		FN_LOAD_Z = 2'd1,
		FN_UPDATE = 2'd2,
		FN_ENERGY = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOAD_J1,
		ST_LOAD_J2,
		ST_LOAD_Z,
		ST_WALK_START,
		ST_WALK,
		ST_OMQ,
		ST_TERM,
		ST_FSUM,
		ST_ABS,
		ST_NORM,
		ST_SQUARE,
		ST_SQSUM,
		ST_SQRT,
		ST_DIVZ_INIT,
		ST_DIVZ,
		ST_DIVX_INIT,
		ST_DIVX,
		ST_COMMIT,
		ST_EMUL,
		ST_EACC,
		ST_EFIN,
		ST_RESULT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_WR_J1,
		OP_WR_J2,
		OP_WR_Z,
		OP_WALK_START,
		OP_WALK,
		OP_OMQ,
		OP_TERM,
		OP_FSUM,
		OP_ABS,
		OP_NORM,
		OP_SQUARE,
		OP_SQSUM,
		OP_SQRT,
		OP_DIV_INIT_Z,
		OP_DIV_INIT_X,
		OP_DIV_STEP,
		OP_COMMIT,
		OP_EMUL,
		OP_EACC,
		OP_EFIN,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  walk_done;
		logic  norm_done;
		logic  sqrt_done;
		logic  div_done;
		logic  erow_last;
		logic  out_free;
	} dp_status_t;

	typedef struct packed {
		func_t              func;
		logic [IDX_W-1:0]   row_index;
		logic [IDX_W-1:0]   col_index;
		logic signed [15:0] load_value;
		logic [15:0]        transverse_field;
	} item_t;

	typedef struct packed {
		logic signed [15:0] spin_z;
		logic [14:0]        spin_x;
		logic               spin_changed;
		logic signed [31:0] energy;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/mfsa_if.sv]
// Request, result and configuration channel interfaces of the spin annealer.
`default_nettype none

interface mfsa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [4:0]  row_index;
	logic [4:0]  col_index;
	logic signed [15:0] load_value;
	logic [15:0] transverse_field;

	modport source (output valid, func, row_index, col_index, load_value,
		transverse_field, input ready);
	modport sink (input valid, func, row_index, col_index, load_value,
		transverse_field, output ready);
endinterface

interface mfsa_res_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] spin_z;
	logic [14:0] spin_x;
	logic        spin_changed;
	logic signed [31:0] energy;

	modport source (output valid, spin_z, spin_x, spin_changed, energy, input ready);
	modport sink (input valid, spin_z, spin_x, spin_changed, energy, output ready);
endinterface

interface mfsa_cfg_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] field_bias;

	modport source (output valid, field_bias, input ready);
	modport sink (input valid, field_bias, output ready);
endinterface

`default_nettype wire

[hw/rtl/mean_field_spin_annealer.sv]
// Top level of the mean-field spin annealer.
`default_nettype none

// Zero-temperature mean-field annealer for a 32-spin glass with a symmetric coupling
// matrix (Q3.12), z spin components (Q1.15) and x spin components (unsigned Q0.15).
// Each request either loads one coupling (written to both mirror entries), loads one
// z spin, updates one spin under the transverse field it carries, or reads the energy
// per spin; updates and energy reads return one result, loads return none. Requests
// are handled one at a time. An update consists of a walk over the coupling row (one
// coupling memory read per cycle), up to five normalising shifts, a 32-step bit-serial
// square root and two restoring divisions that share one divider. An energy read
// repeats the row walk for every spin. A finished result waits in an output register,
// so the next request is taken while it is still unclaimed. The field_bias register is
// written through its own channel, which is always ready, and must only be written
// while the block is idle. Couplings and z spins read before they have been loaded
// return whatever the memories hold; x spins reset to zero.

module mean_field_spin_annealer import mfsa_pkg::*; (
	input wire         clk,
	input wire         arst_n,
	mfsa_req_if.sink   req,
	mfsa_res_if.source res,
	mfsa_cfg_if.sink   cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;
	item_t      item;
	result_t    out_data;
	logic       out_valid;

	// The request payload is gathered into one struct for the datapath.
	assign item.func             = func_t'(req.func);
	assign item.row_index        = req.row_index;
	assign item.col_index        = req.col_index;
	assign item.load_value       = req.load_value;
	assign item.transverse_field = req.transverse_field;

	// The bias register takes every write at once.
	assign cfg.ready = 1'b1;

	mfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mfsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item      (item),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.field_bias),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (res.ready)
	);

	// Result channel driven straight from the output register.
	assign res.valid        = out_valid;
	assign res.spin_z       = out_data.spin_z;
	assign res.spin_x       = out_data.spin_x;
	assign res.spin_changed = out_data.spin_changed;
	assign res.energy       = out_data.energy;

endmodule

`default_nettype wire

[hw/rtl/mfsa_ctrl.sv]
// Sequencing state machine of the spin annealer.
`default_nettype none

module mfsa_ctrl import mfsa_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (status.func)
					FN_LOAD_J: state_d = ST_LOAD_J1;
					FN_LOAD_Z: state_d = ST_LOAD_Z;
					default:   state_d = ST_WALK_START;
				endcase
			end
			ST_LOAD_J1:    state_d = ST_LOAD_J2;
			ST_LOAD_J2:    state_d = ST_IDLE;
			ST_LOAD_Z:     state_d = ST_IDLE;
			ST_WALK_START: state_d = ST_WALK;
			ST_WALK: begin
				if (status.walk_done) begin
					state_d = (status.func == FN_ENERGY) ? ST_EMUL : ST_OMQ;
				end
			end
			ST_OMQ:    state_d = ST_TERM;
			ST_TERM:   state_d = ST_FSUM;
			ST_FSUM:   state_d = ST_ABS;
			ST_ABS:    state_d = ST_NORM;
			ST_NORM: begin
				if (status.norm_done) state_d = ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_SQSUM;
			ST_SQSUM:  state_d = ST_SQRT;
			ST_SQRT: begin
				if (status.sqrt_done) state_d = ST_DIVZ_INIT;
			end
			ST_DIVZ_INIT: state_d = ST_DIVZ;
			ST_DIVZ: begin
				if (status.div_done) state_d = ST_DIVX_INIT;
			end
			ST_DIVX_INIT: state_d = ST_DIVX;
			ST_DIVX: begin
				if (status.div_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: state_d = ST_RESULT;
			ST_EMUL:   state_d = ST_EACC;
			ST_EACC:   state_d = status.erow_last ? ST_EFIN : ST_WALK_START;
			ST_EFIN:   state_d = ST_RESULT;
			ST_RESULT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd.op = OP_CAPTURE;
			end
			ST_LOAD_J1:    cmd.op = OP_WR_J1;
			ST_LOAD_J2:    cmd.op = OP_WR_J2;
			ST_LOAD_Z:     cmd.op = OP_WR_Z;
			ST_WALK_START: cmd.op = OP_WALK_START;
			ST_WALK:       cmd.op = OP_WALK;
			ST_OMQ:        cmd.op = OP_OMQ;
			ST_TERM:       cmd.op = OP_TERM;
			ST_FSUM:       cmd.op = OP_FSUM;
			ST_ABS:        cmd.op = OP_ABS;
			ST_NORM: begin
				if (!status.norm_done) cmd.op = OP_NORM;
			end
			ST_SQUARE:     cmd.op = OP_SQUARE;
			ST_SQSUM:      cmd.op = OP_SQSUM;
			ST_SQRT: begin
				if (!status.sqrt_done) cmd.op = OP_SQRT;
			end
			ST_DIVZ_INIT:  cmd.op = OP_DIV_INIT_Z;
			ST_DIVX_INIT:  cmd.op = OP_DIV_INIT_X;
			ST_DIVZ, ST_DIVX: begin
				if (!status.div_done) cmd.op = OP_DIV_STEP;
			end
			ST_COMMIT:     cmd.op = OP_COMMIT;
			ST_EMUL:       cmd.op = OP_EMUL;
			ST_EACC:       cmd.op = OP_EACC;
			ST_EFIN:       cmd.op = OP_EFIN;
			ST_RESULT: begin
				if (status.out_free) cmd.op = OP_EMIT;
			end
			default:       cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/mfsa_dp.sv]
// Datapath of the spin annealer: stores, field walk, square root, divider, energy.
`default_nettype none

module mfsa_dp import mfsa_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  item_t              item,
	input  wire                cfg_we,
	input  wire signed [15:0]  cfg_data,
	output result_t            out_data,
	output logic               out_valid,
	input  wire                out_ready
);

	// Stores
	logic signed [15:0] jmem [JMEM_DEPTH];
	logic signed [15:0] zmem [SPIN_COUNT];
	logic [14:0]        x_q [SPIN_COUNT];

	// Item and configuration
	func_t              func_q;
	logic [IDX_W-1:0]   row_q, col_q;
	logic signed [15:0] val_q;
	logic [15:0]        gam_q;
	logic signed [15:0] bias_q;

	// Walk
	logic [CNT_W-1:0]   jc_q;
	logic [IDX_W-1:0]   wrow_q, ei_q, j_s1;
	logic               v_s1, v_s2;
	logic signed [15:0] jrd_s1, zrd_s1, zi_q;
	logic signed [31:0] prod_s2;
	logic [30:0]        sq_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [SQS_W-1:0]   sumsq_q;

	// Field, norm, root, divide
	logic [OMQ_W-1:0]   omq_q;
	logic signed [TPR_W-1:0] tprod_q;
	logic signed [F_W-1:0]   f_q;
	logic               neg_q, fz_q;
	logic [F_W-1:0]     a_q;
	logic [NRM_W-1:0]   b_q;
	logic [SQ_W-1:0]    sqa_q, sqb_q;
	logic [RAD_W-1:0]   rad_q, root_q, bit_q;
	logic [REM_W-1:0]   rem_q;
	logic [QUO_W-1:0]   dsh_q, quo_q, magz_q;
	logic [DCNT_W-1:0]  dcnt_q;

	// Energy
	logic signed [EPR_W-1:0]  eprod_q;
	logic signed [ETOT_W-1:0] etot_q;

	result_t res_q, out_q;
	logic    out_valid_q;

	// Combinational
	logic               issue;
	logic [ADDR_W-1:0]  j_waddr, j_raddr;
	logic               j_we, z_we;
	logic signed [15:0] z_wdata, z_new;
	logic [14:0]        x_new;
	logic [HEFF_W-1:0]  heff;
	logic               heff_nz, zwrite, xwrite;
	logic [RAD_W-1:0]   sq_t;
	logic [REM_W-1:0]   trial;
	logic [NUM_W-1:0]   num;
	logic signed [ETOT_W:0] eneg, esh;
	logic signed [31:0] esat;
	logic               out_free;

	assign heff    = root_q[HEFF_W-1:0];
	assign heff_nz = (heff != '0);
	assign zwrite  = heff_nz && !fz_q;
	assign xwrite  = heff_nz && (gam_q != '0);
	assign issue   = (cmd.op == OP_WALK) && (jc_q != CNT_W'(SPIN_COUNT));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		j_raddr = {wrow_q, jc_q[IDX_W-1:0]};
		j_waddr = (cmd.op == OP_WR_J2) ? {col_q, row_q} : {row_q, col_q};
		j_we    = (cmd.op == OP_WR_J1) || (cmd.op == OP_WR_J2);

		if (neg_q) begin
			z_new = 16'(-$signed({1'b0, magz_q}));
		end else if (magz_q > QUO_W'(32767)) begin
			z_new = 16'sh7FFF;
		end else begin
			z_new = $signed(magz_q[15:0]);
		end
		x_new = (quo_q > QUO_W'(32767)) ? 15'h7FFF : quo_q[14:0];

		z_we    = (cmd.op == OP_WR_Z) || ((cmd.op == OP_COMMIT) && zwrite);
		z_wdata = (cmd.op == OP_WR_Z) ? val_q : z_new;

		sq_t  = root_q + bit_q;
		trial = {rem_q[REM_W-2:0], dsh_q[QUO_W-1]};
		if (cmd.op == OP_DIV_INIT_X) begin
			num = {b_q, 15'b0} + NUM_W'(heff >> 1);
		end else begin
			num = {a_q[NRM_W-1:0], 15'b0} + NUM_W'(heff >> 1);
		end

		eneg = -((ETOT_W+1)'(etot_q));
		esh  = eneg >>> E_SH;
		if (esh[ETOT_W:31] == '0 || esh[ETOT_W:31] == '1) begin
			esat = esh[31:0];
		end else begin
			esat = esh[ETOT_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (j_we) jmem[j_waddr] <= val_q;
		jrd_s1 <= jmem[j_raddr];
	end

	always_ff @(posedge clk) begin
		if (z_we) zmem[row_q] <= z_wdata;
		zrd_s1 <= zmem[jc_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q      <= '0;
			jc_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			ei_q        <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < SPIN_COUNT; k++) x_q[k] <= '0;
		end else begin
			if (cfg_we) bias_q <= cfg_data;
			case (cmd.op)
				OP_CAPTURE: ei_q <= '0;
				OP_WALK_START: begin
					jc_q <= '0;
					v_s1 <= 1'b0;
					v_s2 <= 1'b0;
				end
				OP_WALK: begin
					if (issue) jc_q <= jc_q + CNT_W'(1);
					v_s1 <= issue;
					v_s2 <= v_s1;
				end
				OP_EACC:   ei_q <= ei_q + IDX_W'(1);
				OP_COMMIT: begin
					if (xwrite) x_q[row_q] <= x_new;
				end
				default: ;
			endcase
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= jc_q[IDX_W-1:0];
		if (cmd.op == OP_EMIT) out_q <= res_q;
		case (cmd.op)
			OP_CAPTURE: begin
				func_q <= item.func;
				row_q  <= item.row_index;
				col_q  <= item.col_index;
				val_q  <= item.load_value;
				gam_q  <= item.transverse_field;
				etot_q <= '0;
			end
			OP_WALK_START: begin
				wrow_q  <= (func_q == FN_ENERGY) ? ei_q : row_q;
				acc_q   <= '0;
				sumsq_q <= '0;
			end
			OP_WALK: begin
				if (v_s1) begin
					prod_s2 <= (j_s1 == wrow_q) ? 32'sd0 : jrd_s1 * zrd_s1;
					sq_s2   <= 31'(32'(zrd_s1) * 32'(zrd_s1));
					if (j_s1 == wrow_q) zi_q <= zrd_s1;
				end
				if (v_s2) begin
					acc_q   <= acc_q + ACC_W'(prod_s2);
					sumsq_q <= sumsq_q + SQS_W'(sq_s2);
				end
			end
			OP_OMQ: omq_q <= OMQ_W'((SQS_W+1)'(1) << 30) - OMQ_W'(sumsq_q >> IDX_W);
			OP_TERM: tprod_q <= TPR_W'($signed({1'b0, omq_q})) * TPR_W'(zi_q);
			OP_FSUM: f_q <= F_W'(acc_q) + (F_W'(bias_q) <<< 15) - F_W'(tprod_q >>> 18);
			OP_ABS: begin
				neg_q <= f_q[F_W-1];
				fz_q  <= (f_q == '0);
				a_q   <= f_q[F_W-1] ? F_W'(-f_q) : F_W'(f_q);
				b_q   <= NRM_W'({gam_q, 12'b0});
			end
			OP_NORM: begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
			end
			OP_SQUARE: begin
				sqa_q <= a_q[NRM_W-1:0] * a_q[NRM_W-1:0];
				sqb_q <= b_q * b_q;
			end
			OP_SQSUM: begin
				rad_q  <= RAD_W'(sqa_q) + RAD_W'(sqb_q);
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
			end
			OP_SQRT: begin
				if (rad_q >= sq_t) begin
					rad_q  <= rad_q - sq_t;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIV_INIT_Z, OP_DIV_INIT_X: begin
				if (cmd.op == OP_DIV_INIT_X) magz_q <= quo_q;
				rem_q  <= REM_W'(num >> QUO_W);
				dsh_q  <= num[QUO_W-1:0];
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			OP_DIV_STEP: begin
				if (trial >= REM_W'(heff)) begin
					rem_q <= trial - REM_W'(heff);
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dsh_q  <= dsh_q << 1;
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			OP_COMMIT: begin
				res_q.spin_z       <= zwrite ? z_new : zi_q;
				res_q.spin_x       <= xwrite ? x_new : x_q[row_q];
				res_q.spin_changed <= heff_nz;
				res_q.energy       <= '0;
			end
			OP_EMUL: eprod_q <= EPR_W'(acc_q) * EPR_W'(zi_q);
			OP_EACC: etot_q <= etot_q + ETOT_W'(eprod_q >>> 16);
			OP_EFIN: begin
				res_q.spin_z       <= '0;
				res_q.spin_x       <= '0;
				res_q.spin_changed <= 1'b0;
				res_q.energy       <= esat;
			end
			default: ;
		endcase
	end

	assign status.func      = func_q;
	assign status.walk_done = (jc_q == CNT_W'(SPIN_COUNT)) && !v_s1 && !v_s2;
	assign status.norm_done = (a_q[F_W-1:NRM_W] == '0);
	assign status.sqrt_done = (bit_q == '0);
	assign status.div_done  = (dcnt_q == DCNT_W'(QUO_W));
	assign status.erow_last = (ei_q == IDX_W'(SPIN_COUNT - 1));
	assign status.out_free  = out_free;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
